[rtl/core/seq_versioned_topic_merge_table_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the versioned topic merge table
// Concurrent checks that are compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SEQ_VERSIONED_TOPIC_MERGE_TABLE_MACROS_SVH
`define SEQ_VERSIONED_TOPIC_MERGE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define VTMT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define VTMT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `VTMT_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define VTMT_ASSERT(label, clk, rst_n, prop, msg)

`define VTMT_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[rtl/core/vtmt_pkg.sv]
// ----------------------------------------------------------------------------
// vtmt_pkg
// Types and constants shared by the versioned topic merge table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtmt_pkg;

  localparam int KEY_FIELD_W  = 64;
  localparam int LEN_W        = 8;
  localparam int SEQ_W        = 16;
  localparam int QOS_W        = 8;
  localparam int SCOPE_W      = 8;
  localparam int SLOT_FIELD_W = 4;
  localparam int CNT_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SEQ_W-1:0] SERIAL_HALF = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_TOMBSTONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION    = 2'd2;

  localparam logic [SEQ_W-1:0]   TOMBSTONE_RST = 16'hFFFF;
  localparam logic [LEN_W-1:0]   MAX_LEN_RST   = 8'd64;
  localparam logic [SCOPE_W-1:0] REGION_RST    = 8'd1;

  typedef enum logic [2:0] {
    ACT_EMPTY       = 3'd0,
    ACT_TOO_LONG    = 3'd1,
    ACT_SKIPPED     = 3'd2,
    ACT_UPDATED     = 3'd3,
    ACT_RECOVERED   = 3'd4,
    ACT_TOMB_DONE   = 3'd5,
    ACT_TOMB_ABSENT = 3'd6,
    ACT_FULL        = 3'd7
  } action_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DECIDE = 1'b1
  } state_e;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] topic_key;
    logic [LEN_W-1:0]       data_length;
    logic [SEQ_W-1:0]       sequence_req;
    logic [QOS_W-1:0]       qos_level;
    logic [SCOPE_W-1:0]     scope_code;
  } entry_t;

  typedef struct packed {
    action_e                 action;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [CNT_W-1:0]        merged_total;
    logic [CNT_W-1:0]        skipped_total;
    logic [CNT_W-1:0]        recovered_total;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

[rtl/core/vtmt_stream_if.sv]
// ----------------------------------------------------------------------------
// vtmt_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtmt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/vtmt_ctrl.sv]
// ----------------------------------------------------------------------------
// vtmt_ctrl
// Sequencer: capture an entry, then commit it once the result register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "seq_versioned_topic_merge_table_macros.svh"

module vtmt_ctrl
  import vtmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts_i.out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECIDE: begin
        cmd_o.commit = !sts_i.out_stall;
      end
      default: ;
    endcase
  end

  `VTMT_ASSERT(a_capture_to_decide, clk_i, rst_ni, cmd_o.capture |=> state_q == ST_DECIDE, "capture did not enter decide")
  `VTMT_ASSERT(a_commit_to_idle, clk_i, rst_ni, cmd_o.commit |=> state_q == ST_IDLE, "commit did not return to idle")
  `VTMT_ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, state_q == ST_DECIDE && in_ready_o, "ready while an entry is pending")

endmodule

[rtl/core/vtmt_dp.sv]
// ----------------------------------------------------------------------------
// vtmt_dp
// Slot table, key match, serial sequence compare, counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "seq_versioned_topic_merge_table_macros.svh"

module vtmt_dp
  import vtmt_pkg::*;
#(
  parameter int TOPIC_SLOTS = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t sts_o,
  input  entry_t     entry_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  cfg_wr_t    cfg_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);

  localparam int SLOT_W = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;

  // configuration
  logic [SEQ_W-1:0]   tomb_q;
  logic [LEN_W-1:0]   max_len_q;
  logic [SCOPE_W-1:0] region_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tomb_q    <= TOMBSTONE_RST;
      max_len_q <= MAX_LEN_RST;
      region_q  <= REGION_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.index)
        CFG_TOMBSTONE: tomb_q    <= cfg_i.data;
        CFG_MAX_LEN:   max_len_q <= cfg_i.data[LEN_W-1:0];
        CFG_REGION:    region_q  <= cfg_i.data[SCOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // slot table
  logic [TOPIC_SLOTS-1:0] open_q;
  logic [KEY_BITS-1:0]    key_q    [TOPIC_SLOTS];
  logic [SEQ_W-1:0]       seq_q    [TOPIC_SLOTS];
  logic [LEN_W-1:0]       len_q    [TOPIC_SLOTS];
  logic [QOS_W-1:0]       qos_q    [TOPIC_SLOTS];
  logic                   region_f_q [TOPIC_SLOTS];

  // captured entry and lookup vectors
  entry_t                 ent_q;
  logic [TOPIC_SLOTS-1:0] hit_q, hit_d;
  logic [TOPIC_SLOTS-1:0] free_q;

  always_comb begin
    for (int i = 0; i < TOPIC_SLOTS; i++) begin
      hit_d[i] = open_q[i] && (key_q[i] == entry_i.topic_key[KEY_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      free_q <= '0;
    end else if (cmd_i.capture) begin
      hit_q  <= hit_d;
      free_q <= ~open_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) ent_q <= entry_i;
  end

  // lowest set bit of each vector
  logic              hit_any, free_any;
  logic [SLOT_W-1:0] hit_idx, free_idx;

  always_comb begin
    hit_any  = |hit_q;
    free_any = |free_q;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TOPIC_SLOTS - 1; i >= 0; i--) begin
      if (hit_q[i])  hit_idx  = SLOT_W'(i);
      if (free_q[i]) free_idx = SLOT_W'(i);
    end
  end

  // decision
  logic [SEQ_W-1:0]  seq_diff;
  logic              newer;
  action_e           action;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_shown;

  logic [CNT_W-1:0] merge_q, merge_d;
  logic [CNT_W-1:0] skip_q, skip_d;
  logic [CNT_W-1:0] rec_q, rec_d;

  assign seq_diff = ent_q.sequence_req - seq_q[hit_idx];
  assign newer    = (seq_diff != '0) && (seq_diff < SERIAL_HALF);

  always_comb begin
    action     = ACT_EMPTY;
    slot_idx   = hit_idx;
    slot_shown = 1'b0;
    priority if (ent_q.data_length == '0) begin
      if (ent_q.sequence_req != tomb_q) begin
        action = ACT_EMPTY;
      end else if (hit_any) begin
        action     = ACT_TOMB_DONE;
        slot_shown = 1'b1;
      end else begin
        action = ACT_TOMB_ABSENT;
      end
    end else if (ent_q.data_length > max_len_q) begin
      action = ACT_TOO_LONG;
    end else if (hit_any) begin
      action     = newer ? ACT_UPDATED : ACT_SKIPPED;
      slot_shown = 1'b1;
    end else if (free_any) begin
      action     = ACT_RECOVERED;
      slot_idx   = free_idx;
      slot_shown = 1'b1;
    end else begin
      action = ACT_FULL;
    end
  end

  always_comb begin
    merge_d = merge_q;
    skip_d  = skip_q;
    rec_d   = rec_q;
    unique case (action)
      ACT_UPDATED, ACT_TOMB_DONE: merge_d = merge_q + 1'b1;
      ACT_SKIPPED:                skip_d  = skip_q + 1'b1;
      ACT_RECOVERED:              rec_d   = rec_q + 1'b1;
      default: ;
    endcase
  end

  // commit
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      merge_q     <= '0;
      skip_q      <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        merge_q     <= merge_d;
        skip_q      <= skip_d;
        rec_q       <= rec_d;
        out_valid_q <= 1'b1;
        if (action == ACT_TOMB_DONE) open_q[slot_idx] <= 1'b0;
        if (action == ACT_RECOVERED) open_q[slot_idx] <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_o.action          <= action;
      out_o.slot            <= slot_shown ? SLOT_FIELD_W'(slot_idx) : '0;
      out_o.merged_total    <= merge_d;
      out_o.skipped_total   <= skip_d;
      out_o.recovered_total <= rec_d;
      if (action == ACT_UPDATED || action == ACT_RECOVERED) begin
        seq_q[slot_idx] <= ent_q.sequence_req;
        len_q[slot_idx] <= ent_q.data_length;
      end
      if (action == ACT_RECOVERED) begin
        key_q[slot_idx]      <= ent_q.topic_key[KEY_BITS-1:0];
        qos_q[slot_idx]      <= ent_q.qos_level;
        region_f_q[slot_idx] <= (ent_q.scope_code == region_q);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  `VTMT_ASSERT(a_commit_room, clk_i, rst_ni, cmd_i.commit |-> !out_valid_q || out_ready_i, "commit over a pending result")
  `VTMT_ASSERT_NEVER(a_hit_free_overlap, clk_i, rst_ni, (hit_q & free_q) != '0, "slot both matched and free")
  `VTMT_ASSERT(a_recover_count, clk_i, rst_ni, cmd_i.commit && action == ACT_RECOVERED |=> rec_q == $past(rec_q) + 1'b1, "recover counter did not advance")

endmodule

[rtl/core/seq_versioned_topic_merge_table.sv]
// An entry is taken only while idle, so a new one waits for the last commit.
// The key match over all slots is registered at capture; priority select,
// table write-back and the result register follow in the decide state,
// which stretches while an earlier result waits unaccepted at the output.
// Reset: slot open flags, counters and result valid clear at once; config
// returns to defaults; no clearing pass, so entries are taken right after.
// ----------------------------------------------------------------------------
// seq_versioned_topic_merge_table
// Last-writer-wins merge of replicated topic entries using serial numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seq_versioned_topic_merge_table
  import vtmt_pkg::*;
#(
  parameter int TOPIC_SLOTS = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vtmt_stream_if.sink   in_i,
  vtmt_stream_if.source out_o,
  vtmt_stream_if.sink   cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;
  logic       cfg_ready;
  logic       out_valid;
  result_t    result;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = cfg_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = result;

  vtmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vtmt_dp #(
    .TOPIC_SLOTS (TOPIC_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .entry_i     (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_ready),
    .cfg_i       (cfg_i.data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_o       (result)
  );

endmodule

[tb/seq_versioned_topic_merge_table_tb.sv]
// ----------------------------------------------------------------------------
// seq_versioned_topic_merge_table_tb
// Drives replicated topic entries and register writes into the merge table
// and checks every result against a cycle-free model of the slot table kept
// here. A short directed table covers the boundary cases, then random phases
// under several register settings and both-sided backpressure follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seq_versioned_topic_merge_table_tb;
  import vtmt_pkg::*;

  localparam int TOPIC_SLOTS  = 16;
  localparam int KEY_BITS     = 64;
  localparam int KEY_POOL     = 20;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [KEY_FIELD_W-1:0] KEY_MASK = {KEY_FIELD_W{1'b1}} >> (64 - KEY_BITS);
  localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED = 2'd3;

  typedef struct packed {
    entry_t                  e;
    logic                    pin;
    action_e                 act;
    logic [SLOT_FIELD_W-1:0] slot;
  } stim_row_t;

  // entry {key, len, seq, qos, scope}, pinned, action, slot
  localparam int DIR_ROWS = 17;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{'{64'h0, 8'd0, 16'h0000, 8'h00, 8'h00}, 1'b1, ACT_EMPTY, 4'd0},
    '{'{64'h0, 8'd0, 16'hFFFF, 8'h00, 8'h00}, 1'b1, ACT_TOMB_ABSENT, 4'd0},
    '{'{64'h0, 8'd65, 16'h0000, 8'h00, 8'h00}, 1'b1, ACT_TOO_LONG, 4'd0},
    '{'{64'h0, 8'd255, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, ACT_TOO_LONG, 4'd0},
    '{'{64'h0, 8'd1, 16'h0000, 8'h00, 8'h01}, 1'b1, ACT_RECOVERED, 4'd0},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 8'd64, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, ACT_RECOVERED, 4'd1},
    '{'{64'h0, 8'd10, 16'h0000, 8'h11, 8'h01}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'h0, 8'd10, 16'h8000, 8'h22, 8'h00}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'h0, 8'd10, 16'h7FFF, 8'h33, 8'h02}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 8'd5, 16'h0000, 8'h44, 8'h01}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'h0, 8'd0, 16'hFFFF, 8'h00, 8'h00}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'h5A5A_A5A5_0F0F_F0F0, 8'd3, 16'h1234, 8'h81, 8'h01}, 1'b1, ACT_RECOVERED, 4'd0},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'hFFFF, 8'h00, 8'h00}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'hFFFF, 8'h00, 8'h00}, 1'b1, ACT_TOMB_ABSENT, 4'd0},
    '{'{64'h5A5A_A5A5_0F0F_F0F0, 8'd64, 16'h1235, 8'h7E, 8'h02}, 1'b0, ACT_EMPTY, 4'd0},
    '{'{64'h5A5A_A5A5_0F0F_F0F0, 8'd65, 16'h1236, 8'h00, 8'h00}, 1'b1, ACT_TOO_LONG, 4'd0},
    '{'{64'h5A5A_A5A5_0F0F_F0F0, 8'd0, 16'h1236, 8'h00, 8'h00}, 1'b1, ACT_EMPTY, 4'd0}
  };

  localparam logic [CFG_DATA_W-1:0] PH_TOMB   [PHASES] = '{16'hFFFF, 16'h0000, 16'h8000,
                                                           16'h0000, 16'h0000, 16'hFFFF};
  localparam logic [CFG_DATA_W-1:0] PH_MAX    [PHASES] = '{16'h0040, 16'hAAFF, 16'h0001,
                                                           16'h0000, 16'h0000, 16'h0010};
  localparam logic [CFG_DATA_W-1:0] PH_REGION [PHASES] = '{16'h0001, 16'h5500, 16'h00FF,
                                                           16'h0000, 16'h0000, 16'h0003};

  logic clk;
  logic rst_n;

  vtmt_stream_if #(.T(entry_t))  in_if  ();
  vtmt_stream_if #(.T(result_t)) out_if ();
  vtmt_stream_if #(.T(cfg_wr_t)) cfg_if ();

  seq_versioned_topic_merge_table #(
    .TOPIC_SLOTS (TOPIC_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // table model
  logic                   table_open   [TOPIC_SLOTS];
  logic [KEY_FIELD_W-1:0] table_key    [TOPIC_SLOTS];
  logic [SEQ_W-1:0]       table_seq    [TOPIC_SLOTS];
  logic [LEN_W-1:0]       table_len    [TOPIC_SLOTS];
  logic [QOS_W-1:0]       table_qos    [TOPIC_SLOTS];
  logic                   table_region [TOPIC_SLOTS];
  logic [CNT_W-1:0]       merge_cnt;
  logic [CNT_W-1:0]       skip_cnt;
  logic [CNT_W-1:0]       recover_cnt;
  logic [SEQ_W-1:0]       cur_tombstone;
  logic [LEN_W-1:0]       cur_max_len;
  logic [SCOPE_W-1:0]     cur_region;

  result_t   expected_q [$];
  stim_row_t offered_q  [$];
  int        errors;
  int        idle_cycles;

  int                     send_gap_pct;
  int                     recv_idle_pct;
  logic                   hold_req;
  logic                   hold;
  logic [SEQ_W-1:0]       gen_tomb;
  logic [LEN_W-1:0]       gen_max;
  logic [SCOPE_W-1:0]     gen_region;
  logic [KEY_FIELD_W-1:0] key_pool [KEY_POOL];
  logic [SEQ_W-1:0]       pool_seq [KEY_POOL];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t predict_merge(entry_t e);
    result_t                r;
    logic [KEY_FIELD_W-1:0] key;
    logic [SEQ_W-1:0]       diff;
    int                     hit;
    int                     free_slot;
    int                     i;
    key = e.topic_key & KEY_MASK;
    hit = -1;
    free_slot = -1;
    for (i = 0; i < TOPIC_SLOTS; i++) begin
      if (hit < 0 && table_open[i] && table_key[i] == key) hit = i;
      if (free_slot < 0 && !table_open[i]) free_slot = i;
    end
    r.slot = '0;
    if (e.data_length == '0) begin
      if (e.sequence_req != cur_tombstone) begin
        r.action = ACT_EMPTY;
      end else if (hit >= 0) begin
        table_open[hit] = 1'b0;
        merge_cnt++;
        r.action = ACT_TOMB_DONE;
        r.slot = SLOT_FIELD_W'(hit);
      end else begin
        r.action = ACT_TOMB_ABSENT;
      end
    end else if (e.data_length > cur_max_len) begin
      r.action = ACT_TOO_LONG;
    end else if (hit >= 0) begin
      diff = e.sequence_req - table_seq[hit];
      r.slot = SLOT_FIELD_W'(hit);
      if (diff == '0 || diff >= SERIAL_HALF) begin
        skip_cnt++;
        r.action = ACT_SKIPPED;
      end else begin
        table_len[hit] = e.data_length;
        table_seq[hit] = e.sequence_req;
        merge_cnt++;
        r.action = ACT_UPDATED;
      end
    end else if (free_slot >= 0) begin
      table_key[free_slot]    = key;
      table_len[free_slot]    = e.data_length;
      table_seq[free_slot]    = e.sequence_req;
      table_qos[free_slot]    = e.qos_level;
      table_region[free_slot] = (e.scope_code == cur_region);
      table_open[free_slot]   = 1'b1;
      recover_cnt++;
      r.action = ACT_RECOVERED;
      r.slot = SLOT_FIELD_W'(free_slot);
    end else begin
      r.action = ACT_FULL;
    end
    r.merged_total    = merge_cnt;
    r.skipped_total   = skip_cnt;
    r.recovered_total = recover_cnt;
    return r;
  endfunction

  // mostly well-formed traffic on a small key pool so the table fills and drains
  function automatic entry_t make_entry();
    entry_t e;
    int     r;
    int     k;
    int     m;
    r = $urandom_range(99);
    k = $urandom_range(KEY_POOL - 1);
    e.topic_key    = key_pool[k];
    e.sequence_req = SEQ_W'($urandom);
    e.qos_level    = QOS_W'($urandom);
    e.scope_code   = ($urandom_range(99) < 30) ? gen_region : SCOPE_W'($urandom);
    if (r < 8) begin
      e.data_length  = '0;
      e.sequence_req = gen_tomb;
    end else if (r < 12) begin
      e.data_length = '0;
    end else if (r < 17) begin
      e.data_length = (gen_max < 8'd255) ? LEN_W'($urandom_range(255, gen_max + 1))
                                         : LEN_W'($urandom_range(255, 1));
    end else if (r < 22) begin
      e.topic_key   = {$urandom, $urandom};
      e.data_length = LEN_W'($urandom);
    end else begin
      e.data_length = (gen_max == '0) ? LEN_W'($urandom_range(255, 1))
                                      : LEN_W'($urandom_range(gen_max, 1));
      m = $urandom_range(99);
      if (m < 60)      e.sequence_req = pool_seq[k] + SEQ_W'($urandom_range(3, 1));
      else if (m < 70) e.sequence_req = pool_seq[k];
      else if (m < 80) e.sequence_req = pool_seq[k] - SEQ_W'($urandom_range(3, 1));
      else if (m < 85) e.sequence_req = pool_seq[k] + SERIAL_HALF;
      pool_seq[k] = e.sequence_req;
    end
    return e;
  endfunction

  task automatic send_entry(input stim_row_t row);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= row.e;
    offered_q.push_back(row);
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx, d};
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  always @(posedge clk) begin
    stim_row_t row;
    result_t   want;
    result_t   got;
    if (!rst_n) begin
      for (int i = 0; i < TOPIC_SLOTS; i++) table_open[i] = 1'b0;
      merge_cnt     = '0;
      skip_cnt      = '0;
      recover_cnt   = '0;
      cur_tombstone = TOMBSTONE_RST;
      cur_max_len   = MAX_LEN_RST;
      cur_region    = REGION_RST;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          CFG_TOMBSTONE: cur_tombstone = cfg_if.data.data[SEQ_W-1:0];
          CFG_MAX_LEN:   cur_max_len   = cfg_if.data.data[LEN_W-1:0];
          CFG_REGION:    cur_region    = cfg_if.data.data[SCOPE_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        row  = offered_q.pop_front();
        want = predict_merge(in_if.data);
        if (row.pin) begin
          want.action = row.act;
          want.slot   = row.slot;
        end
        expected_q.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: result with none expected: act=%0d slot=%0d",
                     $time, got.action, got.slot);
        end else begin
          want = expected_q.pop_front();
          if (got.action !== want.action || got.slot !== want.slot ||
              got.merged_total !== want.merged_total ||
              got.skipped_total !== want.skipped_total ||
              got.recovered_total !== want.recovered_total) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: mismatch exp act=%0d slot=%0d m=%0d s=%0d r=%0d",
                       $time, want.action, want.slot, want.merged_total,
                       want.skipped_total, want.recovered_total,
                       "  got act=%0d slot=%0d m=%0d s=%0d r=%0d",
                       got.action, got.slot, got.merged_total,
                       got.skipped_total, got.recovered_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= !hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("seq_versioned_topic_merge_table_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] tomb;
    logic [CFG_DATA_W-1:0] maxd;
    logic [CFG_DATA_W-1:0] region;
    stim_row_t             row;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    errors        = 0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    send_gap_pct  = 24;
    recv_idle_pct = 67;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < KEY_POOL; i++) pool_seq[i] = SEQ_W'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_entry(DIRECTED[i]);
    in_if.valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        send_gap_pct  = 24;
        recv_idle_pct = 67;
      end else if (ph < 4) begin
        send_gap_pct  = 67;
        recv_idle_pct = 24;
      end else begin
        send_gap_pct  = 0;
        recv_idle_pct = 0;
      end
      // let the last transfer reach the expected queue first
      @(posedge clk);
      while (expected_q.size() != 0) @(posedge clk);
      repeat (2) @(posedge clk);
      tomb   = PH_TOMB[ph];
      maxd   = PH_MAX[ph];
      region = PH_REGION[ph];
      if (ph == 3 || ph == 4) begin
        tomb   = CFG_DATA_W'($urandom);
        region = CFG_DATA_W'($urandom);
      end
      if (ph == 4) maxd = CFG_DATA_W'($urandom);
      cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
      cfg_write(CFG_TOMBSTONE, tomb);
      cfg_write(CFG_MAX_LEN, maxd);
      cfg_write(CFG_REGION, region);
      cfg_if.valid <= 1'b0;
      gen_tomb   = tomb;
      gen_max    = maxd[LEN_W-1:0];
      gen_region = region[SCOPE_W-1:0];
      if (ph == 1) hold_req <= 1'b1;
      row.pin  = 1'b0;
      row.act  = ACT_EMPTY;
      row.slot = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        row.e = make_entry();
        send_entry(row);
      end
      in_if.valid <= 1'b0;
    end

    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    errors += expected_q.size();
    if (errors == 0) begin
      $display("seq_versioned_topic_merge_table_tb: clean");
    end else begin
      $display("seq_versioned_topic_merge_table_tb: errors");
    end
    $finish;
  end

endmodule
